// ----- hdl/ckx_pkg.sv -----
`default_nettype none
package ckx_pkg;

  localparam int WORD_W = 32;
  localparam int ROW_W  = 64;

  // APB: registers on 8-byte strides, six of them
  localparam int APB_AW       = 6;
  localparam int APB_DW       = 64;
  localparam int REG_ADDR_LSB = 3;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_KEY_01   = 3'd0;
  localparam reg_idx_t REG_KEY_23   = 3'd1;
  localparam reg_idx_t REG_KEY_45   = 3'd2;
  localparam reg_idx_t REG_KEY_67   = 3'd3;
  localparam reg_idx_t REG_NONCE_LO = 3'd4;
  localparam reg_idx_t REG_NONCE_HI = 3'd5;

  localparam logic [3:0] CHUNK_BYTES = 4'd8;

  // quarter-round step codes within one double round
  typedef logic [2:0] step_t;
  localparam step_t STEP_LAST_COL  = 3'd3;
  localparam step_t STEP_LAST_DIAG = 3'd7;

  localparam logic [WORD_W-1:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } ckx_cfg_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] counter;
    logic [2:0]        sel;
  } ckx_core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ckx_core_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ckx_if.sv -----
`default_nettype none
interface ckx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_counter;
  logic [2:0]  chunk_index;
  logic [63:0] text_in;
  logic [3:0]  byte_count;

  modport source (output valid, block_counter, chunk_index, text_in, byte_count,
                  input ready);
  modport sink (input valid, block_counter, chunk_index, text_in, byte_count,
                output ready);
endinterface

interface ckx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] text_out;
  logic [3:0]  valid_bytes;

  modport source (output valid, text_out, valid_bytes, input ready);
  modport sink (input valid, text_out, valid_bytes, output ready);
endinterface
`default_nettype wire

// ----- hdl/ckx_quarter.sv -----
`default_nettype none
module ckx_quarter (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] c_i,
  input  wire logic [31:0] d_i,
  output logic [31:0]      a_o,
  output logic [31:0]      b_o,
  output logic [31:0]      c_o,
  output logic [31:0]      d_o
);

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
  logic [31:0] dx1, bx1, dx2, bx2;

  always_comb begin
    a1  = a_i + b_i;
    dx1 = d_i ^ a1;
    d1  = {dx1[15:0], dx1[31:16]};
    c1  = c_i + d1;
    bx1 = b_i ^ c1;
    b1  = {bx1[19:0], bx1[31:20]};
    a2  = a1 + b1;
    dx2 = d1 ^ a2;
    d2  = {dx2[23:0], dx2[31:24]};
    c2  = c1 + d2;
    bx2 = b1 ^ c2;
    b2  = {bx2[24:0], bx2[31:25]};
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule
`default_nettype wire

// ----- hdl/ckx_apb_regs.sv -----
`default_nettype none
module ckx_apb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ckx_pkg::APB_AW-1:0] paddr,
  input  wire logic [ckx_pkg::APB_DW-1:0] pwdata,
  output logic [ckx_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  output ckx_pkg::ckx_cfg_t               cfg_o
);

  logic [31:0] key_r [8];
  logic [31:0] nonce_r [3];
  ckx_pkg::reg_idx_t idx;
  logic wr_en;

  assign idx    = paddr[ckx_pkg::APB_AW-1:ckx_pkg::REG_ADDR_LSB];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ckx_pkg::REG_KEY_01: begin
          key_r[0] <= pwdata[31:0];
          key_r[1] <= pwdata[63:32];
        end
        ckx_pkg::REG_KEY_23: begin
          key_r[2] <= pwdata[31:0];
          key_r[3] <= pwdata[63:32];
        end
        ckx_pkg::REG_KEY_45: begin
          key_r[4] <= pwdata[31:0];
          key_r[5] <= pwdata[63:32];
        end
        ckx_pkg::REG_KEY_67: begin
          key_r[6] <= pwdata[31:0];
          key_r[7] <= pwdata[63:32];
        end
        ckx_pkg::REG_NONCE_LO: begin
          nonce_r[0] <= pwdata[31:0];
          nonce_r[1] <= pwdata[63:32];
        end
        ckx_pkg::REG_NONCE_HI: begin
          nonce_r[2] <= pwdata[31:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ckx_pkg::REG_KEY_01:   prdata = {key_r[1], key_r[0]};
      ckx_pkg::REG_KEY_23:   prdata = {key_r[3], key_r[2]};
      ckx_pkg::REG_KEY_45:   prdata = {key_r[5], key_r[4]};
      ckx_pkg::REG_KEY_67:   prdata = {key_r[7], key_r[6]};
      ckx_pkg::REG_NONCE_LO: prdata = {nonce_r[1], nonce_r[0]};
      ckx_pkg::REG_NONCE_HI: prdata = {32'd0, nonce_r[2]};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) cfg_o.key[i] = key_r[i];
    for (int i = 0; i < 3; i++) cfg_o.nonce[i] = nonce_r[i];
  end

endmodule
`default_nettype wire

// ----- hdl/ckx_round_core.sv -----
`default_nettype none
module ckx_round_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ckx_pkg::ckx_cfg_t       cfg_i,
  input  wire ckx_pkg::ckx_core_req_t  req_i,
  output ckx_pkg::ckx_core_sts_t       sts_o,
  output logic [ckx_pkg::ROW_W-1:0]    ks_row_o
);

  localparam int RoundW = $clog2(DOUBLE_ROUNDS);

  logic [31:0] st_r   [16];
  logic [31:0] st_nxt [16];
  logic [31:0] rot_w  [16];
  logic [31:0] init_w [16];
  logic [ckx_pkg::ROW_W-1:0] ks_r [8];
  logic [31:0] ctr_r;
  logic        run_r, ff_r, done_r;
  ckx_pkg::step_t    step_r;
  logic [RoundW-1:0] round_r;
  logic [31:0] qa, qb, qc, qd;

  always_comb begin
    for (int i = 0; i < 4; i++) init_w[i] = ckx_pkg::SIGMA[i];
    for (int i = 0; i < 8; i++) init_w[4 + i] = cfg_i.key[i];
    init_w[12] = run_r ? ctr_r : req_i.counter;
    for (int i = 0; i < 3; i++) init_w[13 + i] = cfg_i.nonce[i];
  end

  // the shared unit always works on column 0 of the 4x4 state
  ckx_quarter u_qr (
    .a_i (st_r[0]), .b_i (st_r[4]), .c_i (st_r[8]), .d_i (st_r[12]),
    .a_o (qa),      .b_o (qb),      .c_o (qc),      .d_o (qd)
  );

  // after each quarter round every row rotates left one word; after the
  // last column step row r rotates r more (diagonals line up as columns),
  // after the last diagonal step that skew is undone
  always_comb begin
    logic [31:0] q [16];
    logic [1:0]  amt;
    logic [1:0]  src;
    q = st_r;
    q[0]  = qa;
    q[4]  = qb;
    q[8]  = qc;
    q[12] = qd;
    for (int r = 0; r < 4; r++) begin
      amt = 2'd1;
      if (step_r == ckx_pkg::STEP_LAST_COL) amt = 2'd1 + 2'(r);
      else if (step_r == ckx_pkg::STEP_LAST_DIAG) amt = 2'd1 - 2'(r);
      for (int j = 0; j < 4; j++) begin
        src = 2'(j) + amt;
        rot_w[{2'(r), 2'(j)}] = q[{2'(r), src}];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (req_i.start) st_nxt = init_w;
    else if (run_r && !ff_r) st_nxt = rot_w;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (req_i.start) ctr_r <= req_i.counter;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      ff_r    <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
      round_r <= '0;
      for (int k = 0; k < 8; k++) ks_r[k] <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        run_r   <= 1'b1;
        ff_r    <= 1'b0;
        step_r  <= '0;
        round_r <= '0;
      end else if (run_r) begin
        if (ff_r) begin
          run_r  <= 1'b0;
          ff_r   <= 1'b0;
          done_r <= 1'b1;
          for (int k = 0; k < 8; k++) begin
            ks_r[k] <= {st_r[2*k+1] + init_w[2*k+1], st_r[2*k] + init_w[2*k]};
          end
        end else begin
          step_r <= step_r + 3'd1;
          if (step_r == ckx_pkg::STEP_LAST_DIAG) begin
            round_r <= round_r + RoundW'(1);
            if (round_r == RoundW'(DOUBLE_ROUNDS - 1)) ff_r <= 1'b1;
          end
        end
      end
    end
  end

  assign sts_o.busy = run_r;
  assign sts_o.done = done_r;
  assign ks_row_o   = ks_r[req_i.sel];

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_i.start |-> !run_r)
    else $error("block start while rounds running");

  a_done_after_ff: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(ff_r))
    else $error("done without feed-forward cycle");

  a_ff_on_round_edge: assert property (@(posedge clk) disable iff (!rst_n)
    ff_r |-> (step_r == '0))
    else $error("feed-forward not aligned to a double-round boundary");

endmodule
`default_nettype wire

// ----- hdl/chacha20_keystream_xor_top.sv -----
// ChaCha20 keystream XOR (RFC 8439 block layout). Key and nonce are written
// over APB (8-byte stride, six registers); each request carries one 8-byte
// chunk. A request with chunk index 0 builds a new keystream block from the
// counter it carries: one shared quarter-round unit runs one quarter round
// per cycle, eight per double round, then a feed-forward step. Chunks 1 to
// 7 reuse the stored block. Bytes at or past the byte count come out as
// zero; counts above 8 act as 8. Input is not ready while a request is in
// progress; one finished result may wait in the output register while the
// next request is taken.
`default_nettype none
module chacha20_keystream_xor_top #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ckx_in_if.sink                          in_chan,
  ckx_out_if.source                       out_chan,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ckx_pkg::APB_AW-1:0] paddr,
  input  wire logic [ckx_pkg::APB_DW-1:0] pwdata,
  output logic [ckx_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0]  chunk_r;
  logic [63:0] text_r;
  logic [3:0]  cnt_r;
  logic [63:0] out_text_r;
  logic [3:0]  out_cnt_r;
  logic        out_valid_r;
  logic        accept, fire;
  logic [63:0] ks_row, res;

  ckx_pkg::ckx_cfg_t      cfg;
  ckx_pkg::ckx_core_req_t core_req;
  ckx_pkg::ckx_core_sts_t core_sts;

  ckx_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ckx_round_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .req_i    (core_req),
    .sts_o    (core_sts),
    .ks_row_o (ks_row)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid & in_chan.ready;
  assign fire          = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  assign core_req.start   = accept && (in_chan.chunk_index == 3'd0);
  assign core_req.counter = in_chan.block_counter;
  assign core_req.sel     = chunk_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = core_req.start ? ST_WAIT : ST_EMIT;
      ST_WAIT: if (core_sts.done) state_nxt = ST_EMIT;
      ST_EMIT: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      res[8*i +: 8] = (4'(i) < cnt_r) ? (text_r[8*i +: 8] ^ ks_row[8*i +: 8]) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chunk_r <= in_chan.chunk_index;
      text_r  <= in_chan.text_in;
      cnt_r   <= (in_chan.byte_count > ckx_pkg::CHUNK_BYTES) ? ckx_pkg::CHUNK_BYTES
                                                              : in_chan.byte_count;
    end
    if (fire) begin
      out_text_r <= res;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.text_out    = out_text_r;
  assign out_chan.valid_bytes = out_cnt_r;

  a_wait_has_core: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (core_sts.busy || core_sts.done))
    else $error("waiting on an idle round core");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result appeared without an emit cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("request accepted but block still idle");

endmodule
`default_nettype wire
